// ===== sv/chained_hash_map_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Chained hash map assertion macros
// Shared macros for the concurrent checks of the hash map unit.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_UNIT_DEFINES_SVH
`define CHAINED_HASH_MAP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define CHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define CHM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CHM_ASSERT(lbl, prop, msg)
`define CHM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/chm_pkg.sv =====
// ---------------------------------------------------------------------------
// Chained hash map package
// Sizes, codes, state type and bucket hash shared by the hash map files.
// ---------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned BUCKETS    = 256;
  localparam int unsigned POOL_NODES = 1024;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VAL_W      = 32;

  localparam int unsigned BKT_AW  = $clog2(BUCKETS);
  localparam int unsigned NODE_AW = $clog2(POOL_NODES);
  // A link is a node index plus one, zero meaning no node.
  localparam int unsigned LINK_W  = $clog2(POOL_NODES + 1);
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned KV_W    = KEY_W + VAL_W;

  localparam int unsigned S_TDATA_W = ((KEY_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEEK   = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } chm_op_e;

  typedef enum logic [2:0] {
    ST_ADDED       = 3'd0,
    ST_OVERWRITTEN = 3'd1,
    ST_EXISTS      = 3'd2,
    ST_FULL        = 3'd3,
    ST_FOUND       = 3'd4,
    ST_NOT_FOUND   = 3'd5,
    ST_DELETED     = 3'd6,
    ST_CLEARED     = 3'd7
  } chm_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_NODE,
    S_DECIDE,
    S_FREE,
    S_DEL2,
    S_EMIT
  } chm_state_e;

  // XOR fold of the key onto the bucket index.
  function automatic logic [BKT_AW-1:0] chm_hash(input logic [KEY_W-1:0] key);
    logic [BKT_AW-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % BKT_AW] = h[i % BKT_AW] ^ key[i];
    end
    return h;
  endfunction

endpackage

// ===== sv/chm_ram.sv =====
// ---------------------------------------------------------------------------
// Chained hash map generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/chained_hash_map_unit.sv =====
// ---------------------------------------------------------------------------
// Chained hash map unit
// Key-to-value map with separate chaining over a fixed node pool.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | tdata (low bit up)            | tuser (low bit up)
//  ---------+-----------+-------------------------------+--------------------------
//  s_axis   | in        | key[31:0], value[31:0]        | operation[1:0], overwrite
//  m_axis   | out       | value_out[31:0], entry_count  | status[2:0]
//
// One word is worked on at a time. A clear sets the result register on
// acceptance, with no chain walk. Seek, add and delete first read the bucket
// head, then visit the nodes along the bucket chain one at a time, each visit
// waiting on the registered read of the node memories; an add that reuses a
// returned node and a successful delete take an extra step (S_FREE or S_DEL2).
// Reset empties all buckets at once through per-bucket valid bits, so the unit
// takes words straight after reset. A stalled result waits in the output
// register while the next word is already accepted and walked.
//
`include "chained_hash_map_unit_defines.svh"

module chained_hash_map_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // key [31:0], value [63:32]
  input  logic [chm_pkg::S_TDATA_W-1:0] s_tdata_i,
  // operation [1:0], overwrite [2]
  input  logic [2:0]                    s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // value_out [31:0], entry_count [42:32], zero padding above
  output logic [chm_pkg::M_TDATA_W-1:0] m_tdata_o,
  // status [2:0]
  output logic [2:0]                    m_tuser_o
);

  import chm_pkg::*;

  chm_state_e state_q, state_d;

  // Latched request.
  chm_op_e           op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic              ow_q, ow_d;
  logic [BKT_AW-1:0] bkt_q, bkt_d;

  // Chain walk.
  logic [LINK_W-1:0] head_q, head_d;
  logic [LINK_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] prev_q, prev_d;
  logic [LINK_W-1:0] nxt_q, nxt_d;
  logic [VAL_W-1:0]  hval_q, hval_d;
  logic              hit_q, hit_d;

  // Pool bookkeeping.
  logic [LINK_W-1:0] free_q, free_d;
  logic [LINK_W-1:0] fresh_q, fresh_d;
  logic [CNT_W-1:0]  keys_q, keys_d;

  // Result being built.
  chm_status_e       res_status_q, res_status_d;
  logic [VAL_W-1:0]  res_val_q, res_val_d;

  // Output register.
  logic              m_valid_q;
  logic [VAL_W-1:0]  m_val_q;
  logic [CNT_W-1:0]  m_cnt_q;
  chm_status_e       m_status_q;

  // Bucket valid bits: an invalid bucket reads as an empty chain.
  logic [BUCKETS-1:0] bkt_valid_q;
  logic               valid_clr, valid_set;

  // Memory ports.
  logic               bkt_we;
  logic [BKT_AW-1:0]  bkt_waddr, bkt_raddr;
  logic [LINK_W-1:0]  bkt_wdata, bkt_rdata;
  logic               nxt_we;
  logic [NODE_AW-1:0] nxt_waddr;
  logic [LINK_W-1:0]  nxt_wdata, nxt_rdata;
  logic               kv_we;
  logic [NODE_AW-1:0] kv_waddr;
  logic [KV_W-1:0]    kv_wdata, kv_rdata;
  logic [NODE_AW-1:0] node_raddr;

  logic              s_accept;
  logic              emit_load;
  logic [LINK_W-1:0] head_link;
  logic              key_match;
  logic              alloc_en;
  logic [LINK_W-1:0] alloc_link;

  assign s_tready_o = (state_q == S_IDLE);
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign emit_load  = (state_q == S_EMIT) && (!m_valid_q || m_tready_i);
  assign head_link  = bkt_valid_q[bkt_q] ? bkt_rdata : '0;
  assign key_match  = (kv_rdata[KEY_W-1:0] == key_q);

  chm_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  chm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (node_raddr),
    .rdata_o (nxt_rdata)
  );

  chm_ram #(.WIDTH(KV_W), .DEPTH(POOL_NODES)) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (kv_waddr),
    .wdata_i (kv_wdata),
    .raddr_i (node_raddr),
    .rdata_o (kv_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = (chm_op_e'(s_tuser_i[1:0]) == OP_CLEAR) ? S_EMIT : S_HEAD;
        end
      end
      S_HEAD: begin
        state_d = (head_link == '0) ? S_DECIDE : S_NODE;
      end
      S_NODE: begin
        if (key_match || nxt_rdata == '0) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (op_q == OP_ADD && !hit_q && free_q != '0) begin
          state_d = S_FREE;
        end else if (op_q == OP_DELETE && hit_q) begin
          state_d = S_DEL2;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_FREE: state_d = S_EMIT;
      S_DEL2: state_d = S_EMIT;
      S_EMIT: begin
        if (emit_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    ow_d         = ow_q;
    bkt_d        = bkt_q;
    head_d       = head_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    nxt_d        = nxt_q;
    hval_d       = hval_q;
    hit_d        = hit_q;
    free_d       = free_q;
    fresh_d      = fresh_q;
    keys_d       = keys_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    valid_clr    = 1'b0;
    valid_set    = 1'b0;
    bkt_we       = 1'b0;
    bkt_waddr    = bkt_q;
    bkt_wdata    = '0;
    bkt_raddr    = chm_hash(s_tdata_i[KEY_W-1:0]);
    nxt_we       = 1'b0;
    nxt_waddr    = '0;
    nxt_wdata    = '0;
    kv_we        = 1'b0;
    kv_waddr     = '0;
    kv_wdata     = '0;
    node_raddr   = '0;
    alloc_en     = 1'b0;
    alloc_link   = LINK_W'(fresh_q + 1'b1);

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          op_d  = chm_op_e'(s_tuser_i[1:0]);
          ow_d  = s_tuser_i[2];
          key_d = s_tdata_i[KEY_W-1:0];
          val_d = s_tdata_i[KEY_W+VAL_W-1:KEY_W];
          bkt_d = chm_hash(s_tdata_i[KEY_W-1:0]);
          if (chm_op_e'(s_tuser_i[1:0]) == OP_CLEAR) begin
            valid_clr    = 1'b1;
            free_d       = '0;
            fresh_d      = '0;
            keys_d       = '0;
            res_status_d = ST_CLEARED;
            res_val_d    = '0;
          end
        end
      end
      S_HEAD: begin
        head_d     = head_link;
        cur_d      = head_link;
        prev_d     = '0;
        hit_d      = 1'b0;
        node_raddr = NODE_AW'(head_link - 1'b1);
      end
      S_NODE: begin
        if (key_match) begin
          hit_d  = 1'b1;
          nxt_d  = nxt_rdata;
          hval_d = kv_rdata[KV_W-1:KEY_W];
        end else begin
          prev_d     = cur_q;
          cur_d      = nxt_rdata;
          node_raddr = NODE_AW'(nxt_rdata - 1'b1);
        end
      end
      S_DECIDE: begin
        res_val_d = '0;
        case (op_q)
          OP_ADD: begin
            if (hit_q) begin
              if (ow_q) begin
                kv_we        = 1'b1;
                kv_waddr     = NODE_AW'(cur_q - 1'b1);
                kv_wdata     = {val_q, key_q};
                res_status_d = ST_OVERWRITTEN;
              end else begin
                res_status_d = ST_EXISTS;
              end
            end else if (free_q != '0) begin
              // Fetch the link of the returned node for the next cycle.
              node_raddr = NODE_AW'(free_q - 1'b1);
            end else if (fresh_q < LINK_W'(POOL_NODES)) begin
              alloc_en = 1'b1;
              fresh_d  = LINK_W'(fresh_q + 1'b1);
            end else begin
              res_status_d = ST_FULL;
            end
          end
          OP_SEEK: begin
            if (hit_q) begin
              res_val_d    = hval_q;
              res_status_d = ST_FOUND;
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end
          OP_DELETE: begin
            if (hit_q) begin
              res_val_d    = hval_q;
              res_status_d = ST_DELETED;
              if (prev_q == '0) begin
                bkt_we    = 1'b1;
                bkt_wdata = nxt_q;
              end else begin
                nxt_we    = 1'b1;
                nxt_waddr = NODE_AW'(prev_q - 1'b1);
                nxt_wdata = nxt_q;
              end
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end
      S_FREE: begin
        alloc_en   = 1'b1;
        alloc_link = free_q;
        free_d     = nxt_rdata;
      end
      S_DEL2: begin
        nxt_we    = 1'b1;
        nxt_waddr = NODE_AW'(cur_q - 1'b1);
        nxt_wdata = free_q;
        free_d    = cur_q;
        if (keys_q != '0) begin
          keys_d = CNT_W'(keys_q - 1'b1);
        end
      end
      S_EMIT: ;
      default: ;
    endcase

    // New node goes to the head of its bucket chain.
    if (alloc_en) begin
      nxt_we       = 1'b1;
      nxt_waddr    = NODE_AW'(alloc_link - 1'b1);
      nxt_wdata    = head_q;
      kv_we        = 1'b1;
      kv_waddr     = NODE_AW'(alloc_link - 1'b1);
      kv_wdata     = {val_q, key_q};
      bkt_we       = 1'b1;
      bkt_wdata    = alloc_link;
      valid_set    = 1'b1;
      keys_d       = CNT_W'(keys_q + 1'b1);
      res_status_d = ST_ADDED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= '0;
      fresh_q     <= '0;
      keys_q      <= '0;
      bkt_valid_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      keys_q  <= keys_d;
      if (valid_clr) begin
        bkt_valid_q <= '0;
      end else if (valid_set) begin
        bkt_valid_q[bkt_q] <= 1'b1;
      end
      if (emit_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    ow_q         <= ow_d;
    bkt_q        <= bkt_d;
    head_q       <= head_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    nxt_q        <= nxt_d;
    hval_q       <= hval_d;
    hit_q        <= hit_d;
    res_status_q <= res_status_d;
    res_val_q    <= res_val_d;
    if (emit_load) begin
      m_val_q    <= res_val_q;
      m_cnt_q    <= keys_q;
      m_status_q <= res_status_q;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = M_TDATA_W'({m_cnt_q, m_val_q});
  assign m_tuser_o  = m_status_q;

  // Only one word is in flight at a time.
  `CHM_ASSERT(a_one_in_flight, s_accept |=> !s_tready_o, "second word accepted mid-operation")
  // The key count never exceeds the pool.
  `CHM_ASSERT(a_keys_bound, keys_q <= CNT_W'(POOL_NODES), "key count beyond pool size")
  // Fresh allocation never runs past the pool.
  `CHM_ASSERT(a_fresh_bound, fresh_q <= LINK_W'(POOL_NODES), "fresh node index past pool")

endmodule
